/* hw/rtl/stu_pkg.sv */
// Shared types, character codes and helper functions for the string to integer converter.
package stu_pkg;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_XSEEN  = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        count;
    logic               converted;
    logic               overflow;
  } scan_result_t;

  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_ONE  = 6'd1;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_TEN  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_MAX  = 6'd36;
  localparam logic [5:0] DIGIT_BAD = 6'd36;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  // digit value of a character, DIGIT_BAD for anything that is no digit
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] v;
    v = {2'b00, DIGIT_BAD};
    if (c >= CH_ZERO && c <= CH_NINE) v = c - CH_ZERO;
    else if (c >= CH_UA && c <= CH_UZ) v = c - CH_UA + LETTER_OFS;
    else if (c >= CH_LA && c <= CH_LZ) v = c - CH_LA + LETTER_OFS;
    return v[5:0];
  endfunction

  // 0 stays automatic, 1 and anything above 36 fall back to ten
  function automatic logic [5:0] resolve_base(input logic [5:0] b);
    logic [5:0] r;
    r = b;
    if (b == BASE_ONE || b > BASE_MAX) r = BASE_TEN;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

/* hw/rtl/stu_digit_acc.sv */
// Multiply-add of one digit into the magnitude, with exact range check.
module stu_digit_acc #(
  parameter int VALUE_BITS = 32
) (
  input  logic [VALUE_BITS-1:0] mag,
  input  logic [5:0]            base,
  input  logic [5:0]            digit,
  output logic [VALUE_BITS-1:0] sum,
  output logic                  over
);
  import stu_pkg::*;

  localparam int FW = VALUE_BITS + 6;
  localparam logic [FW-1:0] LIMIT = FW'(1) << (VALUE_BITS - 1);

  logic [FW-1:0] full;

  // mag*base+digit above the limit is exactly the overflow case
  assign full = ({6'b0, mag} * {{VALUE_BITS{1'b0}}, base}) + {{VALUE_BITS{1'b0}}, digit};
  assign sum  = full[VALUE_BITS-1:0];
  assign over = full > LIMIT;

endmodule

/* hw/rtl/stu_scanner.sv */
// Scan state machine: one byte per step, emits the result at string end.
module stu_scanner #(
  parameter int VALUE_BITS    = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           char_byte,
  input  logic                 is_last,
  input  logic [5:0]           cfg_base,
  output logic                 emit,
  output stu_pkg::scan_result_t result
);
  import stu_pkg::*;

  localparam logic [VALUE_BITS-1:0] LIMIT = VALUE_BITS'(1) << (VALUE_BITS - 1);

  phase_t                   phase, phase_next;
  logic                     neg, neg_next;
  logic [VALUE_BITS-1:0]    mag, mag_next;
  logic [5:0]               base, base_next;
  logic                     ovf, ovf_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] dend, dend_next;

  logic [POSITION_BITS-1:0] pos_inc;
  logic [5:0]               rb, tb, d;
  logic [VALUE_BITS-1:0]    acc;
  logic                     acc_over;
  logic                     take;

  logic [VALUE_BITS-1:0]    lim, m;
  logic [VALUE_BITS+31:0]   m_wide;
  logic [31:0]              m32;
  logic [POSITION_BITS+15:0] dend_wide;
  logic                     res_ovf;

  assign rb      = resolve_base(cfg_base);
  assign d       = char_value(char_byte);
  assign pos_inc = (pos == '1) ? pos : pos + 1'b1;

  // base a digit is checked against in the current phase
  always_comb begin
    case (phase)
      PH_SKIP: tb = (rb == BASE_AUTO) ? BASE_TEN : rb;
      PH_SIGN: tb = (base == BASE_AUTO) ? BASE_TEN : base;
      PH_ZERO: tb = (base == BASE_AUTO) ? BASE_OCT : base;
      default: tb = base;
    endcase
  end

  stu_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_acc (
    .mag   (mag),
    .base  (tb),
    .digit (d),
    .sum   (acc),
    .over  (acc_over)
  );

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    mag_next   = mag;
    base_next  = base;
    ovf_next   = ovf;
    pos_next   = pos;
    dend_next  = dend;
    take       = 1'b0;
    if (char_byte != CH_NUL) begin
      unique case (phase)
        PH_SKIP: begin
          base_next = rb;
          if (is_space(char_byte)) begin
            pos_next = pos_inc;
          end else if (char_byte == CH_MINUS || char_byte == CH_PLUS) begin
            neg_next   = (char_byte == CH_MINUS);
            pos_next   = pos_inc;
            phase_next = PH_SIGN;
          end else if (char_byte == CH_ZERO && (rb == BASE_AUTO || rb == BASE_HEX)) begin
            pos_next   = pos_inc;
            dend_next  = pos_inc;
            mag_next   = '0;
            phase_next = PH_ZERO;
          end else begin
            take = 1'b1;
          end
        end
        PH_SIGN: begin
          if (char_byte == CH_ZERO && (base == BASE_AUTO || base == BASE_HEX)) begin
            pos_next   = pos_inc;
            dend_next  = pos_inc;
            mag_next   = '0;
            phase_next = PH_ZERO;
          end else begin
            take = 1'b1;
          end
        end
        PH_ZERO: begin
          if (char_byte == CH_LX || char_byte == CH_UX) begin
            pos_next   = pos_inc;
            base_next  = BASE_HEX;
            phase_next = PH_XSEEN;
          end else begin
            take = 1'b1;
          end
        end
        PH_XSEEN, PH_DIGITS: take = 1'b1;
        default: ;
      endcase
      if (take) begin
        base_next = tb;
        if (tb == BASE_AUTO || d >= tb) begin
          phase_next = PH_DONE;
        end else begin
          if (!ovf) begin
            if (acc_over) ovf_next = 1'b1;
            else mag_next = acc;
          end
          pos_next   = pos_inc;
          dend_next  = pos_inc;
          phase_next = PH_DIGITS;
        end
      end
    end
  end

  // result is formed from the state after this byte
  assign emit      = (char_byte == CH_NUL) || is_last;
  assign lim       = neg_next ? LIMIT : LIMIT - 1'b1;
  assign res_ovf   = ovf_next || (mag_next > lim);
  assign m         = res_ovf ? lim : mag_next;
  assign m_wide    = {32'b0, m};
  assign m32       = m_wide[31:0];
  assign dend_wide = {16'b0, dend_next};

  always_comb begin
    result = '0;
    if (dend_next != '0) begin
      result.converted = 1'b1;
      result.count     = dend_wide[15:0];
      result.overflow  = res_ovf;
      result.value     = neg_next ? -$signed(m32) : $signed(m32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && emit)) begin
      phase <= PH_SKIP;
      neg   <= 1'b0;
      mag   <= '0;
      base  <= rst ? BASE_TEN : rb;
      ovf   <= 1'b0;
      pos   <= '0;
      dend  <= '0;
    end else if (step) begin
      phase <= phase_next;
      neg   <= neg_next;
      mag   <= mag_next;
      base  <= base_next;
      ovf   <= ovf_next;
      pos   <= pos_next;
      dend  <= dend_next;
    end
  end

endmodule

/* hw/rtl/string_to_integer.sv */
// Top level of the streaming string to integer converter.
//
// Usage: bytes of a string arrive one beat at a time on in_valid/in_ready
// with char_byte and is_last. Leading white space is skipped, then one sign,
// an optional 0x prefix (base 16 or automatic) and digits of the base are
// taken. A NUL byte ends the string without being scanned; a byte with
// is_last high is scanned and then ends the string. Each string gives one
// result beat on out_valid/out_ready: value (saturated), consumed_count,
// converted and overflow.
// The base is written on the cfg_valid/cfg_ready channel (numeric_base); the
// user must write it only while no string is in flight (the block does not
// enforce this); it is sampled at each string start. Throughput: one byte
// per cycle while in_ready stays high, set by the digit multiply-add in the
// scanner. A terminating byte passes the input register, then its result is
// loaded into the result register, from which the result beat is offered.
// A stalled receiver holds the result register; input keeps flowing until a
// second string end needs the result register, then in_ready drops.
// Reset (rst, synchronous) empties both registers, drops out_valid, restores
// base ten and returns the scanner to white-space skipping.
module string_to_integer #(
  parameter int VALUE_BITS    = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_byte,
  input  logic               is_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         numeric_base,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [15:0]        consumed_count,
  output logic               converted,
  output logic               overflow
);
  import stu_pkg::*;

  // configuration register
  logic [5:0] base_reg;

  // input stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_adv;

  // scanner handshake
  logic         emit;
  scan_result_t res;
  scan_result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) base_reg <= BASE_TEN;
    else if (cfg_valid) base_reg <= numeric_base;
  end

  // a byte leaves the input stage unless it ends a string and the result
  // register is still full and not being taken
  assign s1_adv   = s1_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= char_byte;
      s1_last <= is_last;
    end
  end

  stu_scanner #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .char_byte (s1_byte),
    .is_last   (s1_last),
    .cfg_base  (base_reg),
    .emit      (emit),
    .result    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) out_res <= res;
  end

  assign value          = out_res.value;
  assign consumed_count = out_res.count;
  assign converted      = out_res.converted;
  assign overflow       = out_res.overflow;

`ifndef SYNTHESIS
  a_noconv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !converted |-> value == 0 && consumed_count == 0 && !overflow)
    else $error("result without conversion is not all zero");

  a_ovf_conv: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> converted)
    else $error("overflow flagged without conversion");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("input stage lost a held byte");

  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

/* verif/stu_checker.sv */
`timescale 1ns / 1ps
// Result checker for the string to integer converter: tracks the scan state and compares beats.
module stu_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         char_byte,
  input  logic               is_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [5:0]         numeric_base,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] value,
  input  logic [15:0]        consumed_count,
  input  logic               converted,
  input  logic               overflow,
  output int                 errors,
  output int                 pending
);
  import stu_pkg::*;

  localparam longint unsigned MAG_TOP = 64'h8000_0000;
  localparam int unsigned     POS_TOP = 32'h0000_FFFF;

  logic [5:0]      base_reg;
  phase_t          phase;
  logic            negative;
  longint unsigned mag;
  logic [5:0]      run_base;
  logic            sat;
  int unsigned     pos;
  int unsigned     digits_stop;
  scan_result_t    result_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [5:0] radix_of(input logic [5:0] b);
    if (b == BASE_AUTO) return BASE_AUTO;
    if (b == BASE_ONE || b > BASE_MAX) return BASE_TEN;
    return b;
  endfunction

  function automatic int unsigned digit_val(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
    return 36;
  endfunction

  function automatic void bump();
    if (pos < POS_TOP) pos++;
  endfunction

  function automatic void restart();
    phase       = PH_SKIP;
    negative    = 1'b0;
    mag         = 0;
    run_base    = radix_of(base_reg);
    sat         = 1'b0;
    pos         = 0;
    digits_stop = 0;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    int unsigned     d;
    longint unsigned m;
    d = digit_val(c);
    if (run_base == BASE_AUTO || d >= run_base) begin
      phase = PH_DONE;
      return;
    end
    if (!sat) begin
      if (mag > MAG_TOP / run_base) begin
        sat = 1'b1;
      end else begin
        m = mag * run_base + d;
        if (m > MAG_TOP) sat = 1'b1;
        else mag = m;
      end
    end
    bump();
    digits_stop = pos;
    phase       = PH_DIGITS;
  endfunction

  // a lone '0' may open a hex prefix or pick octal in auto mode
  function automatic void start_number(input logic [7:0] c);
    if (c == CH_ZERO && (run_base == BASE_AUTO || run_base == BASE_HEX)) begin
      bump();
      digits_stop = pos;
      mag         = 0;
      phase       = PH_ZERO;
      return;
    end
    if (run_base == BASE_AUTO) run_base = BASE_TEN;
    take_digit(c);
  endfunction

  function automatic void scan(input logic [7:0] c);
    case (phase)
      PH_SKIP: begin
        run_base = radix_of(base_reg);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          bump();
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          negative = (c == CH_MINUS);
          bump();
          phase = PH_SIGN;
        end else begin
          start_number(c);
        end
      end
      PH_SIGN: start_number(c);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          bump();
          run_base = BASE_HEX;
          phase    = PH_XSEEN;
        end else begin
          if (run_base == BASE_AUTO) run_base = BASE_OCT;
          take_digit(c);
        end
      end
      PH_XSEEN, PH_DIGITS: take_digit(c);
      default: ;
    endcase
  endfunction

  function automatic void predict(input logic [7:0] c, input logic last);
    scan_result_t    r;
    longint unsigned lim;
    longint unsigned m;
    if (c != CH_NUL) scan(c);
    if (c != CH_NUL && !last) return;
    r = '0;
    if (digits_stop != 0) begin
      lim         = negative ? MAG_TOP : MAG_TOP - 1;
      m           = mag;
      r.converted = 1'b1;
      r.count     = digits_stop[15:0];
      if (sat || m > lim) begin
        r.overflow = 1'b1;
        m          = lim;
      end
      m       = negative ? (64'd0 - m) : m;
      r.value = m[31:0];
    end
    result_q.push_back(r);
    restart();
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      base_reg = BASE_TEN;
      restart();
      result_q.delete();
    end else begin
      // compare first: a beat leaving now never stems from a byte entering now
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report($sformatf("result beat (value %0d) with none expected", value));
        end else begin
          want = result_q.pop_front();
          if (value !== want.value)
            report($sformatf("value got %0d want %0d", value, want.value));
          if (consumed_count !== want.count)
            report($sformatf("consumed_count got %0d want %0d", consumed_count, want.count));
          if (converted !== want.converted)
            report($sformatf("converted got %0b want %0b", converted, want.converted));
          if (overflow !== want.overflow)
            report($sformatf("overflow got %0b want %0b", overflow, want.overflow));
        end
      end
      if (cfg_valid && cfg_ready) base_reg = numeric_base;
      if (in_valid && in_ready) predict(char_byte, is_last);
    end
    pending <= result_q.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the string to integer converter: stimulus, idling and verdict.
module tb;
  import stu_pkg::*;

  // a full run sends ~1.6k bytes with random gaps, stalls and drains;
  // this limit leaves a wide margin
  localparam longint LIMIT = 200_000;
  localparam int     RAND_BYTES = 1500;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         char_byte = CH_NUL;
  logic               is_last = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [5:0]         numeric_base = BASE_TEN;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] value;
  logic [15:0]        consumed_count;
  logic               converted;
  logic               overflow;

  int         errors;
  int         pending;
  longint     cycles = 0;
  bit         steady_tx = 1'b0;  // sender never idles while set
  bit         steady_rx = 1'b0;  // receiver never stalls while set
  int         sent_bytes = 0;
  logic [7:0] text[$];           // string being built for the next send

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  string_to_integer i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_byte      (char_byte),
    .is_last        (is_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .numeric_base   (numeric_base),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .consumed_count (consumed_count),
    .converted      (converted),
    .overflow       (overflow)
  );

  stu_checker i_chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_byte      (char_byte),
    .is_last        (is_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .numeric_base   (numeric_base),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .consumed_count (consumed_count),
    .converted      (converted),
    .overflow       (overflow),
    .errors         (errors),
    .pending        (pending)
  );

  // receiver stalls about 30% of cycles unless held steady
  always @(posedge clk) begin
    out_ready <= steady_rx || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One byte beat. Valid is only lowered when a gap is taken, so a
  // back-to-back beat never sees a low and a high in the same step.
  task automatic send_byte(input logic [7:0] c, input logic last);
    if (!steady_tx) begin
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    char_byte <= c;
    is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
  endtask

  // Sends the text; ends on a flagged last byte or on a NUL beat.
  // An empty text always ends on NUL.
  task automatic send_text(input bit nul_end);
    for (int i = 0; i < text.size(); i++)
      send_byte(text[i], !nul_end && (i == text.size() - 1));
    if (nul_end || text.size() == 0)
      send_byte(CH_NUL, 1'(($urandom_range(1))));
  endtask

  task automatic send_str(input string s, input bit nul_end);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(nul_end);
  endtask

  // Sender goes quiet until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Base change only with the scanner idle; the extra cycles cover the
  // two-stage pipeline after the last result beat.
  task automatic set_base(input logic [5:0] b);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid    <= 1'b1;
    numeric_base <= b;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(d - 10);
  endfunction

  // Random string for the given register setting. Mostly well-formed
  // numbers (white space, sign, prefix, digits near the limits), the rest
  // raw byte noise; some get trailing junk after the digits.
  function automatic void make_string(input logic [5:0] cfg);
    int unsigned     r;
    int unsigned     k;
    int unsigned     radix;
    longint unsigned m;
    logic [7:0]      digs[$];
    text.delete();
    if (cfg == BASE_AUTO) radix = 0;
    else if (cfg == BASE_ONE || cfg > BASE_MAX) radix = BASE_TEN;
    else radix = cfg;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(1, 255)));
      return;
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(5);
        text.push_back(k == 5 ? CH_SPACE : CH_TAB + 8'(k));
      end
    end
    r = $urandom_range(99);
    if (r < 25) text.push_back(CH_MINUS);
    else if (r < 40) text.push_back(CH_PLUS);
    if ((radix == 0 || radix == BASE_HEX) && $urandom_range(99) < 40) begin
      text.push_back(CH_ZERO);
      if ($urandom_range(99) < 75) begin
        text.push_back($urandom_range(1) ? CH_LX : CH_UX);
        radix = BASE_HEX;
      end else if (radix == 0) begin
        radix = BASE_OCT;
      end
    end else if (radix == 0) begin
      radix = BASE_TEN;
    end
    r = $urandom_range(99);
    if (r < 20) m = $urandom_range(0, radix * radix);
    else if (r < 55) m = $urandom();
    else if (r < 75) m = 64'h8000_0000 + $urandom_range(0, 6) - 3;  // sign limits
    else m = {$urandom(), $urandom()};
    if (r < 95) begin
      do begin
        digs.push_front(digit_char(int'(m % radix)));
        m = m / radix;
      end while (m != 0);
      if ($urandom_range(9) == 0) digs.push_front(CH_ZERO);
      foreach (digs[i]) text.push_back(digs[i]);
    end
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(1, 255)));
  endfunction

  initial begin
    logic [5:0] phase_base[8];
    int         mark;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, base ten from reset ---
    send_str("0", 0);
    send_str("2147483647", 0);
    send_str("-2147483648", 1);
    send_str("2147483648", 0);                // overflow, positive side
    send_str("-2147483649", 0);               // overflow, negative side
    send_str(" \t\n\v\f\r+42x9", 1);          // all white space, stop at junk
    send_str("", 1);                          // empty string, nothing converted
    send_str("-", 0);                         // sign alone
    send_str("zz", 0);                        // invalid first byte

    // hex: prefix forms, prefix followed by non-hex
    set_base(BASE_HEX);
    send_str("0x7fffffff", 0);
    send_str("-0X80000000", 1);
    send_str("0xg", 0);
    send_str("ffFFffFF1", 0);

    // automatic detection of all three radixes
    set_base(BASE_AUTO);
    send_str("0x1A", 0);
    send_str("017", 1);
    send_str("-19", 0);
    send_str("0x", 0);

    set_base(BASE_MAX);
    send_str("zZ", 0);
    set_base(6'd2);
    send_str("-102", 0);
    set_base(BASE_ONE);                       // acts as ten
    send_str("19", 0);
    set_base(6'd63);                          // above 36, acts as ten
    send_str("9a", 0);
    set_base(BASE_OCT);
    send_str("778", 1);

    // --- random phases ---
    phase_base[0] = BASE_AUTO;
    phase_base[1] = BASE_HEX;
    phase_base[2] = BASE_TEN;
    phase_base[3] = BASE_OCT;
    phase_base[4] = 6'd2;
    phase_base[5] = BASE_MAX;
    phase_base[6] = 6'($urandom_range(0, 63));
    phase_base[7] = 6'($urandom_range(0, 63));
    for (int p = 0; p < 8; p++) begin
      set_base(phase_base[p]);
      // phase three runs with neither side idling
      steady_tx = (p == 3);
      steady_rx = (p == 3);
      mark = sent_bytes;
      while (sent_bytes - mark < RAND_BYTES / 8) begin
        // in the middle of phase five, before each string started there, hold off until all results are in
        if (p == 5 && sent_bytes - mark >= RAND_BYTES / 16 && sent_bytes - mark < RAND_BYTES / 16 + 12)
          drain();
        make_string(phase_base[p]);
        send_text(1'($urandom_range(1)));
      end
    end
    steady_tx = 1'b0;
    steady_rx = 1'b0;

    // wait out the results, then wait on for any stray beat
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
